// File: sv/hsv_to_ws2812_encoder_unit_assert.svh
`ifndef HSV_TO_WS2812_ENCODER_UNIT_ASSERT_SVH
`define HSV_TO_WS2812_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset
`define HSVWS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hsvws check failed");

// Next-cycle implication
`define HSVWS_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hsvws check failed");

`endif

// File: sv/hsvws_pkg.sv
package hsvws_pkg;

   // field widths
   localparam int BYTE_W      = 8;
   localparam int HUE_W       = 13;
   localparam int REM_W       = 10;
   localparam int SEC_W       = 3;
   localparam int TERM_W      = 18;
   localparam int PROD_W      = 26;
   localparam int FRAC_Y_W    = 20;
   localparam int RECIP_W     = 21;
   localparam int CSR_IDX_W   = 2;

   // hexcone arithmetic
   localparam int HUE_PER_SECTOR = 960;
   localparam int SECTOR_COUNT   = 6;
   localparam int SECTOR_MAX_RAW = 8;
   localparam int FULL_SCALE     = 255;
   localparam int FRAC_SCALE     = FULL_SCALE * HUE_PER_SECTOR;
   localparam int FRAC_SHIFT     = 6;
   localparam int FRAC_DIV       = FRAC_SCALE / (1 << FRAC_SHIFT);
   localparam int RECIP_SHIFT    = 32;
   // floor(2^32 / 3825)
   localparam logic [RECIP_W-1:0] FRAC_RECIP = 21'd1122867;

   // result stream
   localparam int RESULT_COUNT = 26;
   localparam int IDX_W        = $clog2(RESULT_COUNT);
   localparam logic [IDX_W-1:0] IDX_LEAD  = '0;
   localparam logic [IDX_W-1:0] IDX_LATCH = IDX_W'(RESULT_COUNT - 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_CODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_CODE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LATCH_BYTES = 2'd2;

   localparam logic [BYTE_W-1:0] ONE_CODE_RST    = 8'd120;
   localparam logic [BYTE_W-1:0] ZERO_CODE_RST   = 8'd96;
   localparam logic [BYTE_W-1:0] LATCH_BYTES_RST = 8'd100;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [BYTE_W-1:0] g;
      logic [BYTE_W-1:0] r;
      logic [BYTE_W-1:0] b;
   } colour_type;

   typedef struct packed {
      logic [BYTE_W-1:0] one_code;
      logic [BYTE_W-1:0] zero_code;
      logic [BYTE_W-1:0] latch_bytes;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

// File: sv/hsvws_if.sv
interface hsvws_req_if;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [hsvws_pkg::HUE_W-1:0]   hue;
   logic [hsvws_pkg::BYTE_W-1:0]  saturation;
   logic [hsvws_pkg::BYTE_W-1:0]  brightness;
   logic [hsvws_pkg::BYTE_W-1:0]  red;
   logic [hsvws_pkg::BYTE_W-1:0]  green;
   logic [hsvws_pkg::BYTE_W-1:0]  blue;

   modport source (output valid, action, hue, saturation, brightness, red, green, blue,
                   input ready);
   modport sink   (input valid, action, hue, saturation, brightness, red, green, blue,
                   output ready);
endinterface

interface hsvws_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [hsvws_pkg::BYTE_W-1:0]  spi_byte;
   logic [hsvws_pkg::BYTE_W-1:0]  repeat_count;
   logic                          last;

   modport source (output valid, spi_byte, repeat_count, last, input ready);
   modport sink   (input valid, spi_byte, repeat_count, last, output ready);
endinterface

interface hsvws_csr_if;
   logic                             valid;
   logic                             ready;
   logic [hsvws_pkg::CSR_IDX_W-1:0]  index;
   logic [hsvws_pkg::BYTE_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/hsvws_front.sv
module hsvws_front (
   input  logic                      clock,
   input  logic                      reset,
   hsvws_req_if.sink                 req_port,
   input  hsvws_pkg::queue_stat_type q_stat,
   output logic                      q_push,
   output hsvws_pkg::colour_type     q_data
);

   localparam int STAGES = 5;

   // pipeline moves as a whole whenever the tail can leave
   logic [STAGES-1:0] vld_ff;
   logic              advance;

   assign advance        = !vld_ff[STAGES-1] || !q_stat.full;
   assign req_port.ready = advance;
   assign q_push         = vld_ff[STAGES-1] && !q_stat.full;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[STAGES-2:0], req_port.valid};
      end
   end

   // stage 1: input word
   logic                              act1_ff;
   logic [hsvws_pkg::HUE_W-1:0]       hue1_ff;
   logic [hsvws_pkg::BYTE_W-1:0]      sat1_ff, val1_ff;
   hsvws_pkg::colour_type             rgb1_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         act1_ff <= req_port.action;
         hue1_ff <= req_port.hue;
         sat1_ff <= req_port.saturation;
         val1_ff <= req_port.brightness;
         rgb1_ff <= '{g: req_port.green, r: req_port.red, b: req_port.blue};
      end
   end

   // sector and remainder by a compare ladder on hue
   logic [3:0]                        sec_raw;
   logic [hsvws_pkg::HUE_W-1:0]       sec_base;
   logic [hsvws_pkg::SEC_W-1:0]       sec_in;
   logic [hsvws_pkg::REM_W-1:0]       rem_in;

   always_comb begin
      sec_raw  = '0;
      sec_base = '0;
      for (int k = 1; k <= hsvws_pkg::SECTOR_MAX_RAW; k++) begin
         if (hue1_ff >= hsvws_pkg::HUE_W'(k * hsvws_pkg::HUE_PER_SECTOR)) begin
            sec_raw  = 4'(k);
            sec_base = hsvws_pkg::HUE_W'(k * hsvws_pkg::HUE_PER_SECTOR);
         end
      end
      if (sec_raw >= 4'(hsvws_pkg::SECTOR_COUNT)) begin
         sec_in = hsvws_pkg::SEC_W'(sec_raw - 4'(hsvws_pkg::SECTOR_COUNT));
      end else begin
         sec_in = hsvws_pkg::SEC_W'(sec_raw);
      end
      rem_in = hsvws_pkg::REM_W'(hue1_ff - sec_base);
   end

   // stage 2
   logic                              act2_ff;
   logic [hsvws_pkg::SEC_W-1:0]       sec2_ff;
   logic [hsvws_pkg::REM_W-1:0]       rem2_ff;
   logic [hsvws_pkg::BYTE_W-1:0]      sat2_ff, val2_ff;
   hsvws_pkg::colour_type             rgb2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         act2_ff <= act1_ff;
         sec2_ff <= sec_in;
         rem2_ff <= rem_in;
         sat2_ff <= sat1_ff;
         val2_ff <= val1_ff;
         rgb2_ff <= rgb1_ff;
      end
   end

   // fraction terms: 244800 - s*rem, 244800 - s*(960-rem), 255 - s
   logic [hsvws_pkg::REM_W-1:0]       rem_cmp;
   logic [hsvws_pkg::TERM_W-1:0]      sr_prod, st_prod, tq_in, tt_in;
   logic [hsvws_pkg::BYTE_W-1:0]      pt_in;

   assign rem_cmp = hsvws_pkg::REM_W'(hsvws_pkg::HUE_PER_SECTOR) - rem2_ff;
   assign sr_prod = hsvws_pkg::TERM_W'(sat2_ff) * hsvws_pkg::TERM_W'(rem2_ff);
   assign st_prod = hsvws_pkg::TERM_W'(sat2_ff) * hsvws_pkg::TERM_W'(rem_cmp);
   assign tq_in   = hsvws_pkg::TERM_W'(hsvws_pkg::FRAC_SCALE) - sr_prod;
   assign tt_in   = hsvws_pkg::TERM_W'(hsvws_pkg::FRAC_SCALE) - st_prod;
   assign pt_in   = hsvws_pkg::BYTE_W'(hsvws_pkg::FULL_SCALE) - sat2_ff;

   // stage 3
   logic                              act3_ff;
   logic [hsvws_pkg::SEC_W-1:0]       sec3_ff;
   logic [hsvws_pkg::BYTE_W-1:0]      val3_ff, pt3_ff;
   logic [hsvws_pkg::TERM_W-1:0]      tq3_ff, tt3_ff;
   hsvws_pkg::colour_type             rgb3_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         act3_ff <= act2_ff;
         sec3_ff <= sec2_ff;
         val3_ff <= val2_ff;
         pt3_ff  <= pt_in;
         tq3_ff  <= tq_in;
         tt3_ff  <= tt_in;
         rgb3_ff <= rgb2_ff;
      end
   end

   // scale by value
   logic [hsvws_pkg::PROD_W-1:0]      xq_in, xt_in;
   logic [2*hsvws_pkg::BYTE_W-1:0]    xp_in;

   assign xq_in = hsvws_pkg::PROD_W'(val3_ff) * hsvws_pkg::PROD_W'(tq3_ff);
   assign xt_in = hsvws_pkg::PROD_W'(val3_ff) * hsvws_pkg::PROD_W'(tt3_ff);
   assign xp_in = (2*hsvws_pkg::BYTE_W)'(val3_ff) * (2*hsvws_pkg::BYTE_W)'(pt3_ff);

   // stage 4
   logic                              act4_ff;
   logic [hsvws_pkg::SEC_W-1:0]       sec4_ff;
   logic [hsvws_pkg::BYTE_W-1:0]      val4_ff;
   logic [hsvws_pkg::PROD_W-1:0]      xq4_ff, xt4_ff;
   logic [2*hsvws_pkg::BYTE_W-1:0]    xp4_ff;
   hsvws_pkg::colour_type             rgb4_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         act4_ff <= act3_ff;
         sec4_ff <= sec3_ff;
         val4_ff <= val3_ff;
         xq4_ff  <= xq_in;
         xt4_ff  <= xt_in;
         xp4_ff  <= xp_in;
         rgb4_ff <= rgb3_ff;
      end
   end

   // /244800 = >>6 then /3825 by reciprocal (estimate low by at most one);
   // /255 on a 16-bit product as (x + x>>8 + 1) >> 8
   localparam int EST_W = hsvws_pkg::FRAC_Y_W + hsvws_pkg::RECIP_W;

   logic [hsvws_pkg::FRAC_Y_W-1:0]    yq_in, yt_in;
   logic [EST_W-1:0]                  eq_prod, et_prod;
   logic [2*hsvws_pkg::BYTE_W:0]      p_sum;

   assign yq_in   = xq4_ff[hsvws_pkg::PROD_W-1:hsvws_pkg::FRAC_SHIFT];
   assign yt_in   = xt4_ff[hsvws_pkg::PROD_W-1:hsvws_pkg::FRAC_SHIFT];
   assign eq_prod = EST_W'(yq_in) * EST_W'(hsvws_pkg::FRAC_RECIP);
   assign et_prod = EST_W'(yt_in) * EST_W'(hsvws_pkg::FRAC_RECIP);
   assign p_sum   = (2*hsvws_pkg::BYTE_W+1)'(xp4_ff)
                  + (2*hsvws_pkg::BYTE_W+1)'(xp4_ff[2*hsvws_pkg::BYTE_W-1:hsvws_pkg::BYTE_W])
                  + (2*hsvws_pkg::BYTE_W+1)'(1);

   // stage 5
   logic                              act5_ff;
   logic [hsvws_pkg::SEC_W-1:0]       sec5_ff;
   logic [hsvws_pkg::BYTE_W-1:0]      val5_ff, p5_ff, eq5_ff, et5_ff;
   logic [hsvws_pkg::FRAC_Y_W-1:0]    yq5_ff, yt5_ff;
   hsvws_pkg::colour_type             rgb5_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         act5_ff <= act4_ff;
         sec5_ff <= sec4_ff;
         val5_ff <= val4_ff;
         p5_ff   <= p_sum[2*hsvws_pkg::BYTE_W-1:hsvws_pkg::BYTE_W];
         eq5_ff  <= eq_prod[hsvws_pkg::RECIP_SHIFT+hsvws_pkg::BYTE_W-1:hsvws_pkg::RECIP_SHIFT];
         et5_ff  <= et_prod[hsvws_pkg::RECIP_SHIFT+hsvws_pkg::BYTE_W-1:hsvws_pkg::RECIP_SHIFT];
         yq5_ff  <= yq_in;
         yt5_ff  <= yt_in;
         rgb5_ff <= rgb4_ff;
      end
   end

   // correct the estimates and pick channels by sector
   logic [hsvws_pkg::FRAC_Y_W-1:0]    rq, rt;
   logic [hsvws_pkg::BYTE_W-1:0]      q_val, t_val;
   hsvws_pkg::colour_type             hsv_rgb;

   always_comb begin
      rq = yq5_ff - hsvws_pkg::FRAC_Y_W'(eq5_ff) * hsvws_pkg::FRAC_Y_W'(hsvws_pkg::FRAC_DIV);
      rt = yt5_ff - hsvws_pkg::FRAC_Y_W'(et5_ff) * hsvws_pkg::FRAC_Y_W'(hsvws_pkg::FRAC_DIV);
      q_val = (rq >= hsvws_pkg::FRAC_Y_W'(hsvws_pkg::FRAC_DIV)) ? eq5_ff + 8'd1 : eq5_ff;
      t_val = (rt >= hsvws_pkg::FRAC_Y_W'(hsvws_pkg::FRAC_DIV)) ? et5_ff + 8'd1 : et5_ff;
      unique case (sec5_ff)
         3'd0:    hsv_rgb = '{r: val5_ff, g: t_val,   b: p5_ff};
         3'd1:    hsv_rgb = '{r: q_val,   g: val5_ff, b: p5_ff};
         3'd2:    hsv_rgb = '{r: p5_ff,   g: val5_ff, b: t_val};
         3'd3:    hsv_rgb = '{r: p5_ff,   g: q_val,   b: val5_ff};
         3'd4:    hsv_rgb = '{r: t_val,   g: p5_ff,   b: val5_ff};
         default: hsv_rgb = '{r: val5_ff, g: p5_ff,   b: q_val};
      endcase
      q_data = act5_ff ? rgb5_ff : hsv_rgb;
   end

endmodule

// File: sv/hsvws_queue.sv
module hsvws_queue #(
   parameter int Depth = hsvws_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  hsvws_pkg::colour_type     push_data,
   input  logic                      pop,
   output hsvws_pkg::colour_type     head,
   output hsvws_pkg::queue_stat_type stat
);

   localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CNT_W = $clog2(Depth + 1);

   hsvws_pkg::colour_type mem_ff [Depth];
   logic [PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]      cnt_ff;

   assign stat.full  = (cnt_ff == CNT_W'(Depth));
   assign stat.empty = (cnt_ff == '0);
   assign head       = mem_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

// File: sv/hsvws_serial.sv
module hsvws_serial (
   input  logic                      clock,
   input  logic                      reset,
   input  hsvws_pkg::cfg_type        cfg,
   input  hsvws_pkg::colour_type     head,
   input  hsvws_pkg::queue_stat_type q_stat,
   output logic                      pop,
   hsvws_rsp_if.source               rsp_port
);

   localparam int SHR_W = 3 * hsvws_pkg::BYTE_W;

   logic                          busy_ff;
   logic [hsvws_pkg::IDX_W-1:0]   idx_ff;
   logic [SHR_W-1:0]              shr_ff;
   logic                          out_vld_ff;
   logic [hsvws_pkg::BYTE_W-1:0]  byte_ff, rep_ff;
   logic                          last_ff;

   logic out_free, emit, emit_last;

   assign out_free  = !out_vld_ff || rsp_port.ready;
   assign emit      = busy_ff && out_free;
   assign emit_last = emit && (idx_ff == hsvws_pkg::IDX_LATCH);
   // next colour is taken when idle, or as the latch word of the current one leaves
   assign pop       = !q_stat.empty && (!busy_ff || emit_last);

   assign rsp_port.valid        = out_vld_ff;
   assign rsp_port.spi_byte     = byte_ff;
   assign rsp_port.repeat_count = rep_ff;
   assign rsp_port.last         = last_ff;

   // sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (pop) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (emit) begin
         idx_ff <= idx_ff + 1'b1;
         if (emit_last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // colour bits, G then R then B, MSB first
   always_ff @(posedge clock) begin
      if (pop) begin
         shr_ff <= head;
      end else if (emit && idx_ff != hsvws_pkg::IDX_LEAD) begin
         shr_ff <= {shr_ff[SHR_W-2:0], 1'b0};
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (emit) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         unique if (idx_ff == hsvws_pkg::IDX_LEAD) begin
            byte_ff <= '0;
            rep_ff  <= 8'd1;
            last_ff <= 1'b0;
         end else if (idx_ff == hsvws_pkg::IDX_LATCH) begin
            byte_ff <= '0;
            rep_ff  <= cfg.latch_bytes;
            last_ff <= 1'b1;
         end else begin
            byte_ff <= shr_ff[SHR_W-1] ? cfg.one_code : cfg.zero_code;
            rep_ff  <= 8'd1;
            last_ff <= 1'b0;
         end
      end
   end

endmodule

// File: sv/hsv_to_ws2812_encoder_unit.sv
// HSV/RGB colour to WS2812 SPI byte encoder. Each accepted colour word (HSV with hue in
// 1/16 degree, or direct RGB) yields 26 result words: a zero byte, 24 pulse-code bytes
// for G, R, B MSB first, and a zero byte whose repeat count is latch_bytes, flagged
// last. Result words leave at up to one per cycle while the sink is ready, and the
// result serializer takes the next colour as the latch word of the current one leaves.
// The HSV path is a five-stage pipeline feeding a QueueDepth-entry colour queue, so
// input is taken while earlier colours are still being sent. Registers are to be
// written over csr_port only while the block is idle; the block itself does not
// enforce this. Writes to an unknown index are dropped.
`include "hsv_to_ws2812_encoder_unit_assert.svh"

module hsv_to_ws2812_encoder_unit #(
   parameter int QueueDepth = hsvws_pkg::QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   hsvws_req_if.sink     req_port,
   hsvws_rsp_if.source   rsp_port,
   hsvws_csr_if.sink     csr_port
);

   hsvws_pkg::cfg_type        cfg_ff;
   hsvws_pkg::colour_type     q_data, q_head;
   hsvws_pkg::queue_stat_type q_stat;
   logic                      q_push, q_pop;

   // register file
   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.one_code    <= hsvws_pkg::ONE_CODE_RST;
         cfg_ff.zero_code   <= hsvws_pkg::ZERO_CODE_RST;
         cfg_ff.latch_bytes <= hsvws_pkg::LATCH_BYTES_RST;
      end else if (csr_port.valid) begin
         unique case (csr_port.index)
            hsvws_pkg::CSR_ONE_CODE:    cfg_ff.one_code    <= csr_port.data;
            hsvws_pkg::CSR_ZERO_CODE:   cfg_ff.zero_code   <= csr_port.data;
            hsvws_pkg::CSR_LATCH_BYTES: cfg_ff.latch_bytes <= csr_port.data;
            default: ;
         endcase
      end
   end

   hsvws_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .q_stat   (q_stat),
      .q_push   (q_push),
      .q_data   (q_data)
   );

   hsvws_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .head      (q_head),
      .stat      (q_stat)
   );

   hsvws_serial u_serial (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .head     (q_head),
      .q_stat   (q_stat),
      .pop      (q_pop),
      .rsp_port (rsp_port)
   );

   // checks
   `HSVWS_ASSERT_IMP(a_no_push_full, q_push, !q_stat.full)
   `HSVWS_ASSERT_IMP(a_no_pop_empty, q_pop, !q_stat.empty)
   `HSVWS_ASSERT_IMP(a_latch_count, rsp_port.valid && rsp_port.last, rsp_port.repeat_count == cfg_ff.latch_bytes && rsp_port.spi_byte == '0)
   `HSVWS_ASSERT_IMP(a_single_count, rsp_port.valid && !rsp_port.last, rsp_port.repeat_count == 8'd1)

endmodule

// File: verif/hsvws_tb_pkg.sv
package hsvws_tb_pkg;

   // how a colour word is given on the request channel
   typedef enum logic {
      COLOUR_HSV = 1'b0,
      COLOUR_RGB = 1'b1
   } colour_form_type;

endpackage

// File: verif/hsvws_checker.sv
module hsvws_checker (
   input  logic        clock,
   input  logic        reset,
   hsvws_req_if        req,
   hsvws_rsp_if        rsp,
   hsvws_csr_if        csr,
   output int unsigned fault_count,
   output int unsigned backlog
);
   import hsvws_pkg::*;
   import hsvws_tb_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [BYTE_W-1:0] spi_byte;
      logic [BYTE_W-1:0] repeat_count;
      logic              last;
   } spi_word_type;

   cfg_type      shadow_cfg;
   spi_word_type pending_words[$];
   int unsigned  reported;
   int unsigned  words_seen;

   // hexcone HSV to RGB, every channel truncated toward zero
   function automatic colour_type hexcone_colour(input logic [HUE_W-1:0]  hue,
                                                 input logic [BYTE_W-1:0] sat,
                                                 input logic [BYTE_W-1:0] val);
      int unsigned sector;
      int unsigned offset;
      int unsigned v;
      int unsigned s;
      int unsigned p;
      int unsigned q;
      int unsigned t;
      colour_type  c;
      sector = (hue / HUE_PER_SECTOR) % SECTOR_COUNT;
      offset = hue % HUE_PER_SECTOR;
      v      = val;
      s      = sat;
      // grey: no sector mixing at all
      if (s == 0) begin
         c.r = val;
         c.g = val;
         c.b = val;
         return c;
      end
      p = (v * (FULL_SCALE - s)) / FULL_SCALE;
      q = (v * (FRAC_SCALE - s * offset)) / FRAC_SCALE;
      t = (v * (FRAC_SCALE - s * (HUE_PER_SECTOR - offset))) / FRAC_SCALE;
      case (sector)
         0: begin
            c.r = val;         c.g = BYTE_W'(t); c.b = BYTE_W'(p);
         end
         1: begin
            c.r = BYTE_W'(q);  c.g = val;        c.b = BYTE_W'(p);
         end
         2: begin
            c.r = BYTE_W'(p);  c.g = val;        c.b = BYTE_W'(t);
         end
         3: begin
            c.r = BYTE_W'(p);  c.g = BYTE_W'(q); c.b = val;
         end
         4: begin
            c.r = BYTE_W'(t);  c.g = BYTE_W'(p); c.b = val;
         end
         default: begin
            c.r = val;         c.g = BYTE_W'(p); c.b = BYTE_W'(q);
         end
      endcase
      return c;
   endfunction

   // one pixel: lead zero, 24 pulse codes G,R,B MSB first, then the latch word
   task automatic queue_pixel(input colour_type c);
      logic [3*BYTE_W-1:0] grb;
      int                  i;
      grb = c;
      pending_words.push_back('{spi_byte: '0, repeat_count: 8'd1, last: 1'b0});
      for (i = 3 * BYTE_W - 1; i >= 0; i--) begin
         pending_words.push_back('{spi_byte: grb[i] ? shadow_cfg.one_code : shadow_cfg.zero_code,
                                   repeat_count: 8'd1, last: 1'b0});
      end
      pending_words.push_back('{spi_byte: '0, repeat_count: shadow_cfg.latch_bytes,
                                last: 1'b1});
   endtask

   task automatic note_fault(input string what, input int unsigned want, input int unsigned got);
      fault_count++;
      if (reported < REPORT_LIMIT) begin
         reported++;
         $display("hsvws: %s at result word %0d: expected %0d, got %0d",
                  what, words_seen, want, got);
      end
   endtask

   // sample all three channels on the rising edge
   always @(posedge clock) begin : monitor
      spi_word_type want;
      colour_type   colour;
      if (reset) begin
         shadow_cfg.one_code    = ONE_CODE_RST;
         shadow_cfg.zero_code   = ZERO_CODE_RST;
         shadow_cfg.latch_bytes = LATCH_BYTES_RST;
         pending_words.delete();
      end else begin
         // result word against the oldest expectation
         if (rsp.valid && rsp.ready) begin
            if (pending_words.size() == 0) begin
               note_fault("unexpected word, spi_byte", 0, rsp.spi_byte);
            end else begin
               want = pending_words.pop_front();
               if (rsp.spi_byte !== want.spi_byte)
                  note_fault("spi_byte", want.spi_byte, rsp.spi_byte);
               if (rsp.repeat_count !== want.repeat_count)
                  note_fault("repeat_count", want.repeat_count, rsp.repeat_count);
               if (rsp.last !== want.last)
                  note_fault("last", want.last, rsp.last);
            end
            words_seen++;
         end
         // register writes; an unknown index is dropped
         if (csr.valid && csr.ready) begin
            case (csr.index)
               CSR_ONE_CODE:    shadow_cfg.one_code    = csr.data;
               CSR_ZERO_CODE:   shadow_cfg.zero_code   = csr.data;
               CSR_LATCH_BYTES: shadow_cfg.latch_bytes = csr.data;
               default: ;
            endcase
         end
         // colour word in
         if (req.valid && req.ready) begin
            if (req.action == COLOUR_RGB) begin
               colour.g = req.green;
               colour.r = req.red;
               colour.b = req.blue;
            end else begin
               colour = hexcone_colour(req.hue, req.saturation, req.brightness);
            end
            queue_pixel(colour);
         end
      end
      backlog = pending_words.size();
   end

endmodule

// File: verif/tb.sv
module tb;
   import hsvws_pkg::*;
   import hsvws_tb_pkg::*;

   localparam int HALF_PERIOD    = 10;
   localparam int RESET_CYCLES   = 7;
   localparam int SETTLE_CYCLES  = 16;
   localparam int STALL_CYCLES   = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int IDLE_PERCENT   = 35;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      colour_form_type   form;
      logic [HUE_W-1:0]  hue;
      logic [BYTE_W-1:0] saturation;
      logic [BYTE_W-1:0] brightness;
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
   } colour_word_type;

   logic        clock = 1'b0;
   logic        reset;
   bit          steady;
   bit          stall_request;
   bit          stall_done;
   int unsigned fault_count;
   int unsigned backlog;
   int unsigned quiet_cycles;

   hsvws_req_if req_if ();
   hsvws_rsp_if rsp_if ();
   hsvws_csr_if csr_if ();

   hsv_to_ws2812_encoder_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   hsvws_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr         (csr_if),
      .fault_count (fault_count),
      .backlog     (backlog)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // give up when no word moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("hsv_to_ws2812_encoder_unit regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result sink: random back-pressure, one long hold-off on request
   initial begin : receiver
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request && !stall_done) begin
            rsp_if.ready <= 1'b0;
            repeat (STALL_CYCLES) @(negedge clock);
            stall_done = 1'b1;
         end else begin
            rsp_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   function automatic colour_word_type hsv(input int unsigned hue, input int unsigned sat,
                                           input int unsigned val);
      colour_word_type w;
      w.form       = COLOUR_HSV;
      w.hue        = HUE_W'(hue);
      w.saturation = BYTE_W'(sat);
      w.brightness = BYTE_W'(val);
      // RGB fields are don't-care here, so keep them busy
      w.red        = BYTE_W'($urandom);
      w.green      = BYTE_W'($urandom);
      w.blue       = BYTE_W'($urandom);
      return w;
   endfunction

   function automatic colour_word_type rgb(input int unsigned r, input int unsigned g,
                                           input int unsigned b);
      colour_word_type w;
      w            = hsv($urandom, $urandom, $urandom);
      w.form       = COLOUR_RGB;
      w.red        = BYTE_W'(r);
      w.green      = BYTE_W'(g);
      w.blue       = BYTE_W'(b);
      return w;
   endfunction

   // mostly HSV in range, with wrapped hues and saturated/black extremes mixed in
   function automatic colour_word_type random_colour();
      colour_word_type w;
      w = hsv(($urandom_range(0, 7) == 0) ? $urandom_range(5760, 8191) : $urandom_range(0, 5759),
              ($urandom_range(0, 7) == 0) ? 255 * $urandom_range(0, 1) : $urandom_range(0, 255),
              ($urandom_range(0, 7) == 0) ? 255 * $urandom_range(0, 1) : $urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0)
         w.form = COLOUR_RGB;
      return w;
   endfunction

   task automatic send_colour(input colour_word_type w);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.action     <= w.form;
      req_if.hue        <= w.hue;
      req_if.saturation <= w.saturation;
      req_if.brightness <= w.brightness;
      req_if.red        <= w.red;
      req_if.green      <= w.green;
      req_if.blue       <= w.blue;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random(input int unsigned count);
      repeat (count) send_colour(random_colour());
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [BYTE_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input logic [BYTE_W-1:0] one_code,
                            input logic [BYTE_W-1:0] zero_code,
                            input logic [BYTE_W-1:0] latch_bytes);
      write_reg(CSR_ONE_CODE, one_code);
      write_reg(CSR_ZERO_CODE, zero_code);
      write_reg(CSR_LATCH_BYTES, latch_bytes);
   endtask

   // stop offering, let every pixel drain, then allow the pipe to empty
   task automatic drain();
      req_if.valid <= 1'b0;
      while (backlog != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.action     = COLOUR_HSV;
      req_if.hue        = '0;
      req_if.saturation = '0;
      req_if.brightness = '0;
      req_if.red        = '0;
      req_if.green      = '0;
      req_if.blue       = '0;
      csr_if.valid      = 1'b0;
      csr_if.index      = CSR_ONE_CODE;
      csr_if.data       = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed colours at the reset codes
      send_colour(rgb(0, 0, 0));
      send_colour(rgb(255, 255, 255));
      send_colour(rgb(8'hAA, 8'h55, 8'h0F));
      send_colour(rgb(1, 128, 254));
      send_colour(hsv(0, 255, 255));
      send_colour(hsv(959, 255, 255));
      send_colour(hsv(960, 255, 255));
      send_colour(hsv(1920, 255, 255));
      send_colour(hsv(2880, 200, 180));
      send_colour(hsv(3840, 255, 255));
      send_colour(hsv(4800, 128, 255));
      send_colour(hsv(5759, 255, 255));
      // hue past 360 degrees wraps round the sectors
      send_colour(hsv(5760, 255, 255));
      send_colour(hsv(8191, 255, 255));
      send_colour(hsv(6720, 100, 200));
      // grey: zero saturation
      send_colour(hsv(1234, 0, 77));
      send_colour(hsv(480, 0, 255));
      // black: zero value, then other saturation and value mixes
      send_colour(hsv(3000, 255, 0));
      send_colour(hsv(4321, 1, 255));
      send_colour(hsv(2000, 254, 1));
      send_colour(hsv(4096, 170, 85));
      drain();

      // extreme codes, zero-length latch, and a write to an unmapped index
      configure(8'hFF, 8'h00, 8'h00);
      write_reg(CSR_UNUSED, BYTE_W'($urandom));
      send_random(80);
      drain();

      // no idling on either side
      configure(8'h00, 8'hFF, 8'hFF);
      steady = 1'b1;
      send_random(70);
      drain();
      steady = 1'b0;

      // sink holds off for a long stretch while words keep coming
      configure(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
      stall_request = 1'b1;
      send_random(80);
      drain();

      // back to the power-on codes
      configure(ONE_CODE_RST, ZERO_CODE_RST, LATCH_BYTES_RST);
      write_reg(CSR_UNUSED, 8'hFF);
      send_random(70);
      drain();

      configure(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
      send_random(50);
      drain();

      if (fault_count == 0 && backlog == 0) begin
         $display("hsv_to_ws2812_encoder_unit regression: pass");
      end else begin
         $display("hsv_to_ws2812_encoder_unit regression: fail");
      end
      $finish;
   end

endmodule
